### hw/rtl/srpg_pkg.sv
// ----------------------------------------------------------------------------
// srpg_pkg
// Shared types and constants for the stepper ramp pulse generator.
// ----------------------------------------------------------------------------
package srpg_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned PERIOD_BITS = 16;

  localparam int unsigned HIGH_TIME_W   = 8;
  localparam int unsigned RAMP_LENGTH_W = 11;
  localparam int unsigned KIND_W        = 2;
  localparam int unsigned TBL_INDEX_W   = 10;
  localparam int unsigned TBL_VALUE_W   = 16;
  localparam int unsigned CFG_INDEX_W   = 2;
  localparam int unsigned CFG_DATA_W    = 11;

  localparam logic [HIGH_TIME_W-1:0]   HIGH_TIME_RST   = 8'd10;
  localparam logic [RAMP_LENGTH_W-1:0] RAMP_LENGTH_RST = 11'd550;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_TIME   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RAMP_LENGTH = 2'd1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ACC  = 2'd1,
    PH_RUN  = 2'd2,
    PH_DEC  = 2'd3
  } phase_e;

endpackage

### hw/rtl/stepper_ramp_pulse_generator_core.sv
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_generator_core
// Table-driven stepper pulse generator with acceleration and deceleration.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (valid/stall) carry a kind: load a period table entry, start
//   a motion cycle, or one time-base tick. Every accepted word yields exactly
//   one output word (valid/stall) with the step, direction, driver enable,
//   busy and cycle-done levels after that word.
//   Config writes (valid/ready, ready always high) set high_time and
//   ramp_length; write them only while no motion cycle runs.
//   Output is registered in the cycle after input accept, one word per cycle
//   unless stalled. The period table sits in one RAM; its read is issued
//   at each step boundary and the registered read data serves as the current
//   period until the next boundary, so no word ever waits on the RAM port.
//   Input stall follows output stall while an output word is held, so a
//   stalled receiver stops intake without losing or repeating a word.
//   Reset clears the control state to idle (pin low, driver off) and loads
//   high_time 10 and ramp_length 550; the table is undefined until loaded.
// ----------------------------------------------------------------------------
module stepper_ramp_pulse_generator_core #(
  parameter int unsigned TableDepth = srpg_pkg::TABLE_DEPTH,
  parameter int unsigned PeriodBits = srpg_pkg::PERIOD_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [srpg_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [srpg_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input words
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [srpg_pkg::KIND_W-1:0]       kind_i,
  input  logic [srpg_pkg::TBL_INDEX_W-1:0]  table_index_i,
  input  logic [srpg_pkg::TBL_VALUE_W-1:0]  table_value_i,
  input  logic                              limit_up_i,
  input  logic                              limit_down_i,
  // output words
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              step_level_o,
  output logic                              direction_level_o,
  output logic                              driver_enable_o,
  output logic                              busy_res_o,
  output logic                              cycle_done_o
);

  import srpg_pkg::*;

  localparam int unsigned AddrW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned RedW  = TBL_INDEX_W + 12;

  // load index modulo the table depth, restoring subtract steps
  function automatic logic [AddrW-1:0] wrap_index(input logic [TBL_INDEX_W-1:0] v);
    logic [RedW-1:0] r;
    logic [RedW-1:0] sub;
    r = RedW'(v);
    for (int k = TBL_INDEX_W - 1; k >= 0; k--) begin
      sub = RedW'(TableDepth) << k;
      if (r >= sub) begin
        r = r - sub;
      end
    end
    return AddrW'(r);
  endfunction

  // registers
  phase_e                   phase_q, phase_d;
  logic [RAMP_LENGTH_W-1:0] step_cnt_q, step_cnt_d;
  logic [AddrW-1:0]         tidx_q, tidx_d;   // step_cnt modulo TableDepth
  logic [PeriodBits-1:0]    tick_cd_q, tick_cd_d;
  logic                     low_q, low_d;
  logic                     up_q, up_d;
  logic                     pin_q, pin_d;
  logic [HIGH_TIME_W-1:0]   high_time_q;
  logic [RAMP_LENGTH_W-1:0] ramp_len_q;

  logic out_valid_q, out_valid_d;
  logic step_lvl_q, dir_lvl_q, busy_q, done_q;

  // handshake
  logic in_acc;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  logic is_idle, is_load, is_start, is_tick;
  assign is_idle  = (phase_q == PH_IDLE);
  assign is_load  = in_acc && (kind_i == KIND_LOAD);
  assign is_start = in_acc && (kind_i == KIND_START) && is_idle;
  assign is_tick  = in_acc && (kind_i == KIND_TICK) && !is_idle;

  // period table
  logic [PeriodBits-1:0] period;
  logic [PeriodBits-1:0] load_val;
  logic                  rd_en;
  logic [AddrW-1:0]      rd_addr;

  assign load_val = PeriodBits'(table_value_i);

  srpg_ram #(
    .Width (PeriodBits),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (is_load),
    .waddr_i (wrap_index(table_index_i)),
    .wdata_i (load_val),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (period)
  );

  // step boundary evaluation
  logic                     bnd;
  phase_e                   bnd_ph;
  logic [RAMP_LENGTH_W-1:0] bnd_sc;
  logic [AddrW-1:0]         bnd_tidx, tidx_inc, tidx_dec;
  logic [RAMP_LENGTH_W-1:0] ramp_eff, sc_dec;
  logic                     lim_hit, ramp_end, cycle_end;
  logic                     up_bnd;

  assign bnd      = is_start || (is_tick && (tick_cd_q <= PeriodBits'(1)) && low_q);
  assign bnd_ph   = is_idle ? PH_ACC : phase_q;
  assign bnd_sc   = is_idle ? '0 : step_cnt_q;
  assign bnd_tidx = is_idle ? '0 : tidx_q;
  assign tidx_inc = (bnd_tidx == AddrW'(TableDepth - 1)) ? '0 : bnd_tidx + 1'b1;
  assign tidx_dec = (bnd_tidx == '0) ? AddrW'(TableDepth - 1) : bnd_tidx - 1'b1;
  assign ramp_eff = (ramp_len_q == '0) ? RAMP_LENGTH_W'(1) : ramp_len_q;
  assign sc_dec   = bnd_sc - 1'b1;
  assign up_bnd   = is_idle ? ~limit_up_i : up_q;
  assign lim_hit  = up_bnd ? limit_up_i : limit_down_i;
  assign ramp_end = (bnd_sc == ramp_eff - 1'b1);
  assign cycle_end = bnd && (bnd_ph == PH_DEC) && (sc_dec == '0);

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (bnd) begin
      unique case (bnd_ph)
        PH_ACC:  phase_d = ramp_end ? PH_RUN : PH_ACC;
        PH_RUN:  phase_d = lim_hit ? PH_DEC : PH_RUN;
        PH_DEC:  phase_d = (sc_dec == '0) ? PH_IDLE : PH_DEC;
        default: phase_d = bnd_ph;
      endcase
    end
  end

  // datapath
  always_comb begin
    step_cnt_d = step_cnt_q;
    tidx_d     = tidx_q;
    tick_cd_d  = tick_cd_q;
    low_d      = low_q;
    up_d       = up_q;
    pin_d      = pin_q;
    rd_en      = 1'b0;
    rd_addr    = tidx_dec;

    if (is_start) begin
      up_d = ~limit_up_i;
    end

    if (bnd) begin
      unique case (bnd_ph)
        PH_ACC: begin
          rd_en      = 1'b1;
          rd_addr    = bnd_tidx;
          step_cnt_d = bnd_sc + 1'b1;
          tidx_d     = tidx_inc;
        end
        PH_RUN: begin
          rd_en   = 1'b1;
          rd_addr = tidx_dec;
        end
        default: begin
          step_cnt_d = sc_dec;
          tidx_d     = tidx_dec;
          rd_en      = (sc_dec != '0);
          rd_addr    = tidx_dec;
        end
      endcase
      if (cycle_end) begin
        pin_d     = 1'b0;
        low_d     = 1'b0;
        tick_cd_d = '0;
      end else begin
        pin_d     = 1'b1;
        low_d     = 1'b0;
        tick_cd_d = PeriodBits'(high_time_q);
      end
    end else if (is_tick) begin
      if (tick_cd_q > PeriodBits'(1)) begin
        tick_cd_d = tick_cd_q - 1'b1;
      end else begin
        // end of high part; read data still holds this step's period
        pin_d     = 1'b0;
        low_d     = 1'b1;
        tick_cd_d = (period > PeriodBits'(high_time_q))
                    ? period - PeriodBits'(high_time_q) : '0;
      end
    end
  end

  assign out_valid_d = in_acc | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      step_cnt_q  <= '0;
      tidx_q      <= '0;
      tick_cd_q   <= '0;
      low_q       <= 1'b0;
      up_q        <= 1'b0;
      pin_q       <= 1'b0;
      high_time_q <= HIGH_TIME_RST;
      ramp_len_q  <= RAMP_LENGTH_RST;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      step_cnt_q  <= step_cnt_d;
      tidx_q      <= tidx_d;
      tick_cd_q   <= tick_cd_d;
      low_q       <= low_d;
      up_q        <= up_d;
      pin_q       <= pin_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_HIGH_TIME:   high_time_q <= cfg_data_i[HIGH_TIME_W-1:0];
          CFG_RAMP_LENGTH: ramp_len_q  <= cfg_data_i[RAMP_LENGTH_W-1:0];
          default:         ;
        endcase
      end
    end
  end

  // output word
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      step_lvl_q <= pin_d;
      dir_lvl_q  <= up_d;
      busy_q     <= (phase_d != PH_IDLE);
      done_q     <= cycle_end;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign step_level_o      = step_lvl_q;
  assign direction_level_o = dir_lvl_q;
  assign driver_enable_o   = busy_q;
  assign busy_res_o        = busy_q;
  assign cycle_done_o      = done_q;

endmodule

### hw/rtl/srpg_ram.sv
// ----------------------------------------------------------------------------
// srpg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srpg_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### bench/tb_stepper_ramp_pulse_generator_core.sv
// ----------------------------------------------------------------------------
// tb_stepper_ramp_pulse_generator_core
// Self-checking bench for the table-driven stepper pulse generator. A short
// table of directed words runs first. Random motion cycles follow: table
// loads, a start, then ticks with random limit switches and stray words.
// Output words are checked against typed levels or a behavioral model of
// the step, ramp and limit logic. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_stepper_ramp_pulse_generator_core;
  import srpg_pkg::*;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
  localparam int QUIET_LIMIT = 5000;

  typedef struct packed {
    logic step;
    logic dir;
    logic drv_en;
    logic busy;
    logic done;
  } levels_t;

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [TBL_INDEX_W-1:0] index;
    logic [TBL_VALUE_W-1:0] value;
    logic                   lim_up;
    logic                   lim_down;
    logic                   typed;
    levels_t                levels;
  } vector_t;

  localparam levels_t IDLE_LEVELS = '0;
  localparam levels_t START_DOWN  = '{step: 1'b1, dir: 1'b0, drv_en: 1'b1,
                                      busy: 1'b1, done: 1'b0};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [KIND_W-1:0] kind_i = KIND_NONE;
  logic [TBL_INDEX_W-1:0] table_index_i = '0;
  logic [TBL_VALUE_W-1:0] table_value_i = '0;
  logic limit_up_i = 1'b0;
  logic limit_down_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic step_level_o;
  logic direction_level_o;
  logic driver_enable_o;
  logic busy_res_o;
  logic cycle_done_o;

  always #6 clk_i = ~clk_i;

  stepper_ramp_pulse_generator_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .table_index_i    (table_index_i),
    .table_value_i    (table_value_i),
    .limit_up_i       (limit_up_i),
    .limit_down_i     (limit_down_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .step_level_o     (step_level_o),
    .direction_level_o(direction_level_o),
    .driver_enable_o  (driver_enable_o),
    .busy_res_o       (busy_res_o),
    .cycle_done_o     (cycle_done_o)
  );

  // directed words; expected levels typed in only where obvious
  vector_t directed_vecs [0:21] = '{
    '{KIND_TICK,  10'd0,    16'h0000, 1'b1, 1'b1, 1'b1, IDLE_LEVELS},
    '{KIND_NONE,  10'd1023, 16'hffff, 1'b1, 1'b1, 1'b1, IDLE_LEVELS},
    '{KIND_LOAD,  10'd1023, 16'hffff, 1'b0, 1'b0, 1'b1, IDLE_LEVELS},
    '{KIND_LOAD,  10'd0,    16'h0000, 1'b0, 1'b0, 1'b1, IDLE_LEVELS},
    '{KIND_START, 10'd0,    16'h0000, 1'b1, 1'b0, 1'b1, START_DOWN},
    '{KIND_TICK,  10'd0,    16'h0000, 1'b0, 1'b0, 1'b0, IDLE_LEVELS},
    '{KIND_START, 10'd0,    16'h0000, 1'b0, 1'b0, 1'b0, IDLE_LEVELS},
    '{KIND_TICK,  10'd0,    16'h0000, 1'b0, 1'b0, 1'b0, IDLE_LEVELS},
    '{KIND_LOAD,  10'd0,    16'h0003, 1'b0, 1'b0, 1'b0, IDLE_LEVELS},
    '{KIND_TICK,  10'd0,    16'h0000, 1'b0, 1'b0, 1'b0, IDLE_LEVELS},
    '{KIND_TICK,  10'd0,    16'h0000, 1'b1, 1'b0, 1'b0, IDLE_LEVELS},
    '{KIND_TICK,  10'd0,    16'h0000, 1'b0, 1'b0, 1'b0, IDLE_LEVELS},
    '{KIND_TICK,  10'd0,    16'h0000, 1'b1, 1'b0, 1'b0, IDLE_LEVELS},
    '{KIND_TICK,  10'd0,    16'h0000, 1'b0, 1'b0, 1'b0, IDLE_LEVELS},
    '{KIND_TICK,  10'd0,    16'h0000, 1'b0, 1'b1, 1'b0, IDLE_LEVELS},
    '{KIND_NONE,  10'd0,    16'h0000, 1'b0, 1'b0, 1'b0, IDLE_LEVELS},
    '{KIND_TICK,  10'd0,    16'h0000, 1'b0, 1'b0, 1'b0, IDLE_LEVELS},
    '{KIND_TICK,  10'd0,    16'h0000, 1'b0, 1'b0, 1'b0, IDLE_LEVELS},
    '{KIND_TICK,  10'd0,    16'h0000, 1'b0, 1'b0, 1'b0, IDLE_LEVELS},
    '{KIND_TICK,  10'd0,    16'h0000, 1'b0, 1'b0, 1'b0, IDLE_LEVELS},
    '{KIND_TICK,  10'd0,    16'h0000, 1'b0, 1'b0, 1'b1, IDLE_LEVELS},
    '{KIND_TICK,  10'd0,    16'h0000, 1'b1, 1'b1, 1'b1, IDLE_LEVELS}
  };

  // motor model state
  logic [PERIOD_BITS-1:0] period_mem [TABLE_DEPTH];
  phase_e                 motion_phase = PH_IDLE;
  logic [10:0]            step_cnt = '0;
  logic [15:0]            tick_left = '0;
  logic                   low_part = 1'b0;
  logic [15:0]            active_period = '0;
  logic                   heading_up = 1'b0;
  logic                   pin_level = 1'b0;
  logic [7:0]             reg_high_time = HIGH_TIME_RST;
  logic [10:0]            reg_ramp_len = RAMP_LENGTH_RST;

  levels_t pending_levels [$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int words_in = 0;
  int words_out = 0;
  int work_words = 0;
  int cycles_ended = 0;
  int cycles_up = 0;
  int reg_writes = 0;
  int quiet_cycles = 0;

  string field_names [5] = '{"cycle_done", "busy_res", "driver_enable",
                             "direction_level", "step_level"};

  task automatic raise_step();
    pin_level = 1'b1;
    low_part  = 1'b0;
    tick_left = 16'(reg_high_time);
  endtask

  // step boundary: picks the next period, reports the end of a cycle
  task automatic pick_period(input logic lu, input logic ld, output logic cycle_end);
    logic [10:0] span;
    logic [10:0] rd_idx;
    span = (reg_ramp_len == 11'd0) ? 11'd1 : reg_ramp_len;
    cycle_end = 1'b0;
    case (motion_phase)
      PH_ACC: begin
        if (step_cnt == span - 11'd1) motion_phase = PH_RUN;
        active_period = period_mem[step_cnt % TABLE_DEPTH];
        step_cnt = step_cnt + 11'd1;
      end
      PH_RUN: begin
        if ((heading_up && lu) || (!heading_up && ld)) motion_phase = PH_DEC;
        rd_idx = step_cnt - 11'd1;
        active_period = period_mem[rd_idx % TABLE_DEPTH];
      end
      default: begin
        step_cnt = step_cnt - 11'd1;
        if (step_cnt == 11'd0) cycle_end = 1'b1;
        else active_period = period_mem[step_cnt % TABLE_DEPTH];
      end
    endcase
  endtask

  task automatic advance_motor(input logic [KIND_W-1:0] kind,
                               input logic [TBL_INDEX_W-1:0] idx,
                               input logic [TBL_VALUE_W-1:0] val,
                               input logic lu, input logic ld,
                               output levels_t lv);
    logic ended;
    ended = 1'b0;
    case (kind)
      KIND_LOAD: period_mem[idx % TABLE_DEPTH] = val;
      KIND_START: begin
        if (motion_phase == PH_IDLE) begin
          heading_up   = !lu;
          motion_phase = PH_ACC;
          step_cnt     = '0;
          if (heading_up) cycles_up++;
          pick_period(lu, ld, ended);
          raise_step();
        end
      end
      KIND_TICK: begin
        if (motion_phase != PH_IDLE) begin
          if (tick_left > 16'd1) begin
            tick_left = tick_left - 16'd1;
          end else if (!low_part) begin
            pin_level = 1'b0;
            low_part  = 1'b1;
            // a period no longer than high_time leaves no low countdown
            tick_left = (active_period > 16'(reg_high_time))
                        ? active_period - 16'(reg_high_time) : 16'd0;
          end else begin
            pick_period(lu, ld, ended);
            if (ended) begin
              motion_phase = PH_IDLE;
              pin_level    = 1'b0;
              low_part     = 1'b0;
              tick_left    = '0;
              cycles_ended++;
            end else begin
              raise_step();
            end
          end
        end
      end
      default: ;
    endcase
    lv = '{step: pin_level, dir: heading_up, drv_en: motion_phase != PH_IDLE,
           busy: motion_phase != PH_IDLE, done: ended};
  endtask

  // called on a rising edge; returns on the edge that takes the word
  task automatic send_word(input logic [KIND_W-1:0] kind,
                           input logic [TBL_INDEX_W-1:0] idx,
                           input logic [TBL_VALUE_W-1:0] val,
                           input logic lu, input logic ld,
                           input logic typed, input levels_t typed_lv);
    levels_t lv;
    logic took;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    table_index_i <= idx;
    table_value_i <= val;
    limit_up_i    <= lu;
    limit_down_i  <= ld;
    took = 1'b0;
    while (!took) begin
      @(negedge clk_i);
      took = !in_stall_o;
      @(posedge clk_i);
    end
    words_in++;
    advance_motor(kind, idx, val, lu, ld, lv);
    pending_levels.push_back(typed ? typed_lv : lv);
  endtask

  // drop input valid and hold off until every word is out
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [7:0] ht, input logic [10:0] rl);
    logic [CFG_INDEX_W-1:0] regs [2];
    logic [CFG_DATA_W-1:0] vals [2];
    logic took;
    regs = '{CFG_HIGH_TIME, CFG_RAMP_LENGTH};
    vals = '{CFG_DATA_W'(ht), rl};
    for (int i = 0; i < 2; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= vals[i];
      took = 1'b0;
      while (!took) begin
        @(negedge clk_i);
        took = cfg_ready_o;
        @(posedge clk_i);
      end
      reg_writes++;
      if (regs[i] == CFG_HIGH_TIME) reg_high_time = vals[i][7:0];
      else reg_ramp_len = vals[i];
    end
    cfg_valid_i <= 1'b0;
  endtask

  // one motion cycle: fill the ramp entries, start, tick until done
  task automatic run_motion(input logic [7:0] ht, input logic [10:0] rl);
    int n;
    int r;
    logic hit;
    logic lu;
    logic ld;
    logic wide;
    levels_t none;
    none = '0;
    settle_idle();
    program_regs(ht, rl);
    n = (rl == 11'd0) ? 1 : int'(rl);
    wide = (n > 16);
    for (int i = 0; i < n; i++) begin
      send_word(KIND_LOAD, TBL_INDEX_W'(i),
                TBL_VALUE_W'(wide ? $urandom_range(3) : $urandom_range(10)),
                1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, none);
      work_words++;
    end
    send_word(KIND_START, TBL_INDEX_W'($urandom), TBL_VALUE_W'($urandom),
              1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, none);
    work_words++;
    while (motion_phase != PH_IDLE) begin
      r = $urandom_range(99);
      if (r < 4) begin
        send_word(KIND_NONE, TBL_INDEX_W'($urandom), TBL_VALUE_W'($urandom),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, none);
      end else if (r < 7) begin
        send_word(KIND_START, TBL_INDEX_W'($urandom), TBL_VALUE_W'($urandom),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, none);
      end else if (r < 10) begin
        // entries past the ramp take any value; they are never read here
        if (wide || $urandom_range(1))
          send_word(KIND_LOAD, TBL_INDEX_W'($urandom_range(n - 1)),
                    TBL_VALUE_W'($urandom_range(10)),
                    1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, none);
        else
          send_word(KIND_LOAD, TBL_INDEX_W'($urandom_range(1023, 16)),
                    TBL_VALUE_W'($urandom), 1'($urandom_range(1)),
                    1'($urandom_range(1)), 1'b0, none);
        work_words++;
      end else begin
        hit = ($urandom_range(3) == 0);
        lu  = heading_up ? hit : 1'($urandom_range(1));
        ld  = heading_up ? 1'($urandom_range(1)) : hit;
        send_word(KIND_TICK, TBL_INDEX_W'($urandom), TBL_VALUE_W'($urandom),
                  lu, ld, 1'b0, none);
        work_words++;
      end
      if ($urandom_range(99) == 0) settle_idle();
    end
    // stray words while idle
    if ($urandom_range(2) == 0)
      send_word($urandom_range(1) ? KIND_TICK : KIND_NONE, TBL_INDEX_W'($urandom),
                TBL_VALUE_W'($urandom), 1'($urandom_range(1)),
                1'($urandom_range(1)), 1'b0, none);
  endtask

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  // output check and watchdog, sampled mid-cycle
  always @(negedge clk_i) begin
    levels_t got;
    levels_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        words_out++;
        got = {step_level_o, direction_level_o, driver_enable_o, busy_res_o,
               cycle_done_o};
        if (pending_levels.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected output word %b", $time, got);
        end else begin
          want = pending_levels.pop_front();
          for (int b = 0; b < 5; b++) begin
            if (got[b] !== want[b]) begin
              mismatches++;
              $display("%0t: %s expected %b got %b", $time, field_names[b],
                       want[b], got[b]);
            end
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles, %0d still expected", $time,
                 quiet_cycles, pending_levels.size());
        $display("tb_stepper_ramp_pulse_generator_core: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int target;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // high_time 0 and ramp length 0 for the directed words
    program_regs(8'd0, 11'd0);
    foreach (directed_vecs[i])
      send_word(directed_vecs[i].kind, directed_vecs[i].index, directed_vecs[i].value,
                directed_vecs[i].lim_up, directed_vecs[i].lim_down,
                directed_vecs[i].typed, directed_vecs[i].levels);

    for (int mode = 0; mode < 3; mode++) begin
      settle_idle();
      send_idle_pct  = (mode == 0) ? 10 : (mode == 1) ? 81 : 0;
      recv_stall_pct = (mode == 0) ? 81 : (mode == 1) ? 10 : 0;
      target = work_words + 200;
      while (work_words < target)
        run_motion($urandom_range(3) == 0 ? 8'($urandom_range(12))
                                          : 8'($urandom_range(4)),
                   $urandom_range(9) == 0 ? 11'd0 : 11'($urandom_range(6, 1)));
    end

    settle_idle();
    repeat (10) @(posedge clk_i);
    $display("covered %0d input words (%0d directed) and %0d output words",
             words_in, $size(directed_vecs), words_out);
    $display("%0d motion cycles ended (%0d moving up), %0d register writes",
             cycles_ended, cycles_up, reg_writes);
    if (mismatches == 0) begin
      $display("tb_stepper_ramp_pulse_generator_core: PASS");
    end else begin
      $display("tb_stepper_ramp_pulse_generator_core: FAIL");
    end
    $finish;
  end

endmodule
